// ----- rtl/rmq_pkg.sv -----
package rmq_pkg;

    localparam int IN_W        = 16;
    localparam int MAG_W       = IN_W + 1;
    localparam int T_W         = 17;
    localparam int TS_W        = IN_W + 3;
    localparam int SQ_W        = 2 * MAG_W;
    localparam int FRAC_SH     = 14;
    localparam int DVD_W       = SQ_W + FRAC_SH;
    localparam int QUO_W       = 33;
    localparam int INIT_W      = DVD_W - QUO_W;
    localparam int DIV_STEPS   = QUO_W;
    localparam int ROOT_W      = 17;
    localparam int RAD_W       = 2 * ROOT_W;
    localparam int SRM_W       = ROOT_W + 2;
    localparam int SQRT_STEPS  = ROOT_W;
    localparam int NUM_LANES   = 4;
    localparam int FIFO_DEPTH  = 2;
    localparam int ONE_Q14     = 16384;
    localparam int OUT_POS_MAX = 32767;
    localparam int OUT_NEG_MAG = 32768;

    localparam int LANE_X = 0;
    localparam int LANE_Y = 1;
    localparam int LANE_Z = 2;
    localparam int LANE_W = 3;

    typedef logic signed [IN_W-1:0] elem_t;

    typedef struct packed {
        elem_t r00;
        elem_t r01;
        elem_t r02;
        elem_t r10;
        elem_t r11;
        elem_t r12;
        elem_t r20;
        elem_t r21;
        elem_t r22;
    } mat_t;

    typedef struct packed {
        elem_t quat_x;
        elem_t quat_y;
        elem_t quat_z;
        elem_t quat_w;
    } quat_t;

    typedef struct packed {
        logic [MAG_W-1:0] mag;
        logic             neg;
    } lane_t;

    typedef struct packed {
        logic [T_W-1:0]                t;
        lane_t [NUM_LANES-1:0]         lane;
    } cls_t;

endpackage

// ----- rtl/rmq_chan_if.sv -----
interface rmq_chan_if #(parameter type payload_t = logic);
    logic     valid;
    logic     ready;
    payload_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/rmq_front.sv -----
module rmq_front (
    input  logic          clk,
    input  logic          rst_n,
    rmq_chan_if.sink      mat,
    output rmq_pkg::cls_t cls,
    output logic          cls_valid,
    input  logic          cls_ready
);
    import rmq_pkg::*;

    function automatic lane_t to_lane(input logic signed [MAG_W-1:0] v);
        lane_t res;
        res.neg = v[MAG_W-1];
        res.mag = v[MAG_W-1] ? MAG_W'(-v) : MAG_W'(v);
        return res;
    endfunction

    function automatic lane_t root_lane(input logic signed [TS_W-1:0] t);
        lane_t res;
        res.neg = 1'b0;
        res.mag = MAG_W'(t);
        return res;
    endfunction

    function automatic logic signed [MAG_W-1:0] sub_el(input elem_t a, input elem_t b);
        return MAG_W'(a) - MAG_W'(b);
    endfunction

    function automatic logic signed [MAG_W-1:0] add_el(input elem_t a, input elem_t b);
        return MAG_W'(a) + MAG_W'(b);
    endfunction

    mat_t                   m;
    logic                   vld_reg, vld_next;
    cls_t                   cls_reg, cls_next;
    logic                   accept;
    logic signed [TS_W-1:0] tr, t_tr, t_x, t_y, t_z;
    logic                   lead_y, lead_z;

    assign m         = mat.data;
    assign mat.ready = !vld_reg || cls_ready;
    assign accept    = mat.valid && mat.ready;
    assign cls       = cls_reg;
    assign cls_valid = vld_reg;

    always_comb
    begin
        tr     = TS_W'(m.r00) + TS_W'(m.r11) + TS_W'(m.r22);
        t_tr   = tr + TS_W'(ONE_Q14);
        t_x    = TS_W'(m.r00) - TS_W'(m.r11) - TS_W'(m.r22) + TS_W'(ONE_Q14);
        t_y    = TS_W'(m.r11) - TS_W'(m.r22) - TS_W'(m.r00) + TS_W'(ONE_Q14);
        t_z    = TS_W'(m.r22) - TS_W'(m.r00) - TS_W'(m.r11) + TS_W'(ONE_Q14);
        // ties keep the lower index
        lead_y = m.r11 > m.r00;
        lead_z = m.r22 > (lead_y ? m.r11 : m.r00);

        cls_next = cls_reg;
        priority if (!tr[TS_W-1] && tr != '0)
        begin
            cls_next.t              = T_W'(t_tr);
            cls_next.lane[LANE_W]   = root_lane(t_tr);
            cls_next.lane[LANE_X]   = to_lane(sub_el(m.r12, m.r21));
            cls_next.lane[LANE_Y]   = to_lane(sub_el(m.r20, m.r02));
            cls_next.lane[LANE_Z]   = to_lane(sub_el(m.r01, m.r10));
        end
        else if (lead_z)
        begin
            cls_next.t              = T_W'(t_z);
            cls_next.lane[LANE_Z]   = root_lane(t_z);
            cls_next.lane[LANE_W]   = to_lane(sub_el(m.r01, m.r10));
            cls_next.lane[LANE_X]   = to_lane(add_el(m.r20, m.r02));
            cls_next.lane[LANE_Y]   = to_lane(add_el(m.r21, m.r12));
        end
        else if (lead_y)
        begin
            cls_next.t              = T_W'(t_y);
            cls_next.lane[LANE_Y]   = root_lane(t_y);
            cls_next.lane[LANE_W]   = to_lane(sub_el(m.r20, m.r02));
            cls_next.lane[LANE_Z]   = to_lane(add_el(m.r12, m.r21));
            cls_next.lane[LANE_X]   = to_lane(add_el(m.r10, m.r01));
        end
        else
        begin
            cls_next.t              = T_W'(t_x);
            cls_next.lane[LANE_X]   = root_lane(t_x);
            cls_next.lane[LANE_W]   = to_lane(sub_el(m.r12, m.r21));
            cls_next.lane[LANE_Y]   = to_lane(add_el(m.r01, m.r10));
            cls_next.lane[LANE_Z]   = to_lane(add_el(m.r02, m.r20));
        end
    end

    always_comb
    begin
        if (accept)
            vld_next = 1'b1;
        else if (cls_ready)
            vld_next = 1'b0;
        else
            vld_next = vld_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= 1'b0;
        else
            vld_reg <= vld_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            cls_reg <= cls_next;
    end

endmodule

// ----- rtl/rmq_fifo.sv -----
module rmq_fifo #(
    parameter int DEPTH = rmq_pkg::FIFO_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  rmq_pkg::cls_t wr_data,
    input  logic          wr_valid,
    output logic          wr_ready,
    output rmq_pkg::cls_t rd_data,
    output logic          rd_valid,
    input  logic          rd_ready
);
    import rmq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cls_t             slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             push, pop;

    assign wr_ready = cnt_reg != CNT_W'(DEPTH);
    assign rd_valid = cnt_reg != '0;
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;
    assign rd_data  = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            cnt_next = cnt_reg + 1'b1;
        else if (pop && !push)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= wr_data;
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(DEPTH))
        else $error("queue count above depth");

    a_cnt_push: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !pop) |=> cnt_reg == $past(cnt_reg) + 1'b1)
        else $error("queue count missed a push");

endmodule

// ----- rtl/rmq_back.sv -----
module rmq_back (
    input  logic          clk,
    input  logic          rst_n,
    input  rmq_pkg::cls_t cls,
    input  logic          cls_valid,
    output logic          cls_ready,
    rmq_chan_if.source    quat
);
    import rmq_pkg::*;

    function automatic elem_t sat_lane(input logic [ROOT_W-1:0] s, input logic neg);
        logic [ROOT_W-1:0] mm;
        logic [ROOT_W-1:0] lim;
        mm  = ROOT_W'((ROOT_W'(s) + 1'b1) >> 1);
        if (s == {ROOT_W{1'b1}})
            mm = {1'b1, {(ROOT_W-1){1'b0}}};
        lim = neg ? ROOT_W'(OUT_NEG_MAG) : ROOT_W'(OUT_POS_MAX);
        if (mm > lim)
            mm = lim;
        return neg ? IN_W'(ROOT_W'(-mm)) : IN_W'(mm);
    endfunction

    // division: index 0 is the squaring stage
    logic [DIV_STEPS:0]   dv_vld_reg;
    logic [T_W-1:0]       dv_t_reg   [DIV_STEPS+1];
    logic [NUM_LANES-1:0] dv_neg_reg [DIV_STEPS+1];
    logic [SQ_W-1:0]      dv_sq_reg  [DIV_STEPS+1][NUM_LANES];
    logic [T_W-1:0]       dv_rem_reg [DIV_STEPS+1][NUM_LANES];
    logic [QUO_W-1:0]     dv_quo_reg [DIV_STEPS+1][NUM_LANES];

    logic [SQRT_STEPS-1:0] sr_vld_reg;
    logic [NUM_LANES-1:0]  sr_neg_reg  [SQRT_STEPS];
    logic [RAD_W-1:0]      sr_rad_reg  [SQRT_STEPS][NUM_LANES];
    logic [SRM_W-1:0]      sr_rem_reg  [SQRT_STEPS][NUM_LANES];
    logic [ROOT_W-1:0]     sr_root_reg [SQRT_STEPS][NUM_LANES];

    logic  out_vld_reg;
    quat_t out_reg, out_next;
    logic  en;
    logic [SQ_W-1:0] sq0 [NUM_LANES];

    assign en         = !out_vld_reg || quat.ready;
    assign cls_ready  = en;
    assign quat.valid = out_vld_reg;
    assign quat.data  = out_reg;

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
            sq0[l] = SQ_W'(cls.lane[l].mag) * SQ_W'(cls.lane[l].mag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_vld_reg[0] <= 1'b0;
        else if (en)
            dv_vld_reg[0] <= cls_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dv_t_reg[0] <= cls.t;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                dv_neg_reg[0][l] <= cls.lane[l].neg;
                dv_sq_reg[0][l]  <= sq0[l];
                // top bits of the dividend sq * 2^14 stay below t
                dv_rem_reg[0][l] <= T_W'(sq0[l][SQ_W-1 -: INIT_W]);
                dv_quo_reg[0][l] <= '0;
            end
        end
    end

    genvar g;
    generate
        for (g = 1; g <= DIV_STEPS; g++)
        begin : g_div
            localparam int B = QUO_W - g;
            logic [NUM_LANES-1:0] nbit;
            logic [T_W:0]         trial [NUM_LANES];
            logic [NUM_LANES-1:0] ge;

            for (genvar l = 0; l < NUM_LANES; l++)
            begin : g_lane
                if (B >= FRAC_SH)
                begin : g_bit
                    assign nbit[l] = dv_sq_reg[g-1][l][B-FRAC_SH];
                end
                else
                begin : g_zero
                    assign nbit[l] = 1'b0;
                end
                assign trial[l] = {dv_rem_reg[g-1][l], nbit[l]};
                assign ge[l]    = trial[l] >= {1'b0, dv_t_reg[g-1]};
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    dv_vld_reg[g] <= 1'b0;
                else if (en)
                    dv_vld_reg[g] <= dv_vld_reg[g-1];
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    dv_t_reg[g]   <= dv_t_reg[g-1];
                    dv_neg_reg[g] <= dv_neg_reg[g-1];
                    for (int l = 0; l < NUM_LANES; l++)
                    begin
                        dv_sq_reg[g][l]  <= dv_sq_reg[g-1][l];
                        dv_rem_reg[g][l] <= ge[l] ? T_W'(trial[l] - {1'b0, dv_t_reg[g-1]})
                                                  : T_W'(trial[l]);
                        dv_quo_reg[g][l] <= {dv_quo_reg[g-1][l][QUO_W-2:0], ge[l]};
                    end
                end
            end
        end

        for (g = 0; g < SQRT_STEPS; g++)
        begin : g_sqrt
            logic                 src_vld;
            logic [NUM_LANES-1:0] src_neg;
            logic [RAD_W-1:0]     src_rad  [NUM_LANES];
            logic [SRM_W-1:0]     src_rem  [NUM_LANES];
            logic [ROOT_W-1:0]    src_root [NUM_LANES];
            logic [SRM_W+1:0]     work     [NUM_LANES];
            logic [SRM_W+1:0]     trial    [NUM_LANES];
            logic [NUM_LANES-1:0] ge;

            if (g == 0)
            begin : g_first
                assign src_vld = dv_vld_reg[DIV_STEPS];
                assign src_neg = dv_neg_reg[DIV_STEPS];
                for (genvar l = 0; l < NUM_LANES; l++)
                begin : g_lane
                    assign src_rad[l]  = RAD_W'(dv_quo_reg[DIV_STEPS][l]);
                    assign src_rem[l]  = '0;
                    assign src_root[l] = '0;
                end
            end
            else
            begin : g_next
                assign src_vld = sr_vld_reg[g-1];
                assign src_neg = sr_neg_reg[g-1];
                for (genvar l = 0; l < NUM_LANES; l++)
                begin : g_lane
                    assign src_rad[l]  = sr_rad_reg[g-1][l];
                    assign src_rem[l]  = sr_rem_reg[g-1][l];
                    assign src_root[l] = sr_root_reg[g-1][l];
                end
            end

            for (genvar l = 0; l < NUM_LANES; l++)
            begin : g_step
                assign work[l]  = {src_rem[l], src_rad[l][RAD_W-1-2*g -: 2]};
                assign trial[l] = (SRM_W+2)'({src_root[l], 2'b01});
                assign ge[l]    = work[l] >= trial[l];
            end

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                    sr_vld_reg[g] <= 1'b0;
                else if (en)
                    sr_vld_reg[g] <= src_vld;
            end

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    sr_neg_reg[g] <= src_neg;
                    for (int l = 0; l < NUM_LANES; l++)
                    begin
                        sr_rad_reg[g][l]  <= src_rad[l];
                        sr_rem_reg[g][l]  <= ge[l] ? SRM_W'(work[l] - trial[l]) : SRM_W'(work[l]);
                        sr_root_reg[g][l] <= {src_root[l][ROOT_W-2:0], ge[l]};
                    end
                end
            end
        end
    endgenerate

    always_comb
    begin
        out_next.quat_x = sat_lane(sr_root_reg[SQRT_STEPS-1][LANE_X],
                                   sr_neg_reg[SQRT_STEPS-1][LANE_X]);
        out_next.quat_y = sat_lane(sr_root_reg[SQRT_STEPS-1][LANE_Y],
                                   sr_neg_reg[SQRT_STEPS-1][LANE_Y]);
        out_next.quat_z = sat_lane(sr_root_reg[SQRT_STEPS-1][LANE_Z],
                                   sr_neg_reg[SQRT_STEPS-1][LANE_Z]);
        out_next.quat_w = sat_lane(sr_root_reg[SQRT_STEPS-1][LANE_W],
                                   sr_neg_reg[SQRT_STEPS-1][LANE_W]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_vld_reg <= 1'b0;
        else if (en)
            out_vld_reg <= sr_vld_reg[SQRT_STEPS-1];
    end

    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= out_next;
    end

    a_out_load: assert property (@(posedge clk) disable iff (!rst_n)
        (en && sr_vld_reg[SQRT_STEPS-1]) |=> out_vld_reg)
        else $error("finished request not loaded into output");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(dv_vld_reg) && $stable(sr_vld_reg)))
        else $error("pipeline moved while output stalled");

endmodule

// ----- rtl/rotation_matrix_to_quaternion.sv -----
// Converts a 3x3 rotation matrix (nine signed Q2.14 elements, row-major) into the quaternion
// x, y, z, w in signed Q2.14, each rounded to nearest and saturated. One request is taken
// every cycle while the output is not stalled. Each request passes the classify register,
// the queue, the squaring multiplier, the one-bit-per-stage divider and the two-bit-per-stage
// square root, which loads the output register. Every component, including the root one, goes
// through the same lane: round(sqrt(16384 * d * d / t) / 2). A stalled output freezes the
// back pipeline, while the front keeps filling the queue.
module rotation_matrix_to_quaternion #(
    parameter int FIFO_DEPTH = rmq_pkg::FIFO_DEPTH
) (
    input  logic       clk,
    input  logic       rst_n,
    rmq_chan_if.sink   mat,
    rmq_chan_if.source quat
);
    import rmq_pkg::*;

    cls_t front_cls, queue_cls;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat       (mat),
        .cls       (front_cls),
        .cls_valid (front_valid),
        .cls_ready (front_ready)
    );

    rmq_fifo #(
        .DEPTH (FIFO_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_data  (front_cls),
        .wr_valid (front_valid),
        .wr_ready (front_ready),
        .rd_data  (queue_cls),
        .rd_valid (queue_valid),
        .rd_ready (queue_ready)
    );

    rmq_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cls       (queue_cls),
        .cls_valid (queue_valid),
        .cls_ready (queue_ready),
        .quat      (quat)
    );

endmodule
